@@ rtl/qph_pkg.sv @@
// Shared types and constants for the quadratic-probe hash table.
// No dependencies.
`timescale 1ns / 1ps

package qph_pkg;

  localparam int SIZE_W    = 15;
  localparam int SLOT_W    = 14;
  localparam int COUNT_W   = 15;
  localparam int OUTCOME_W = 3;

  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 15'd16381;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [OUTCOME_W-1:0] OUT_INSERTED      = 3'd0;
  localparam logic [OUTCOME_W-1:0] OUT_INSERT_FAILED = 3'd1;
  localparam logic [OUTCOME_W-1:0] OUT_FOUND         = 3'd2;
  localparam logic [OUTCOME_W-1:0] OUT_EMPTY         = 3'd3;
  localparam logic [OUTCOME_W-1:0] OUT_EXHAUSTED     = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_INIT,
    ST_READ,
    ST_CHECK
  } state_t;

  typedef struct packed {
    logic clr;
    logic start;
    logic div_step;
    logic probe_init;
    logic rd;
    logic advance;
    logic wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic slot_empty;
    logic key_match;
    logic last_probe;
    logic is_lookup;
    logic out_busy;
  } sts_t;

endpackage

@@ rtl/qph_if.sv @@
// Valid/ready channel interfaces for the request and result streams.
// Depends on qph_pkg for field widths.
`timescale 1ns / 1ps

interface qph_in_if #(parameter int KEY_WIDTH = 32);
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [KEY_WIDTH-1:0] key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink   (input valid, input opcode, input key, output ready);
endinterface

interface qph_out_if;
  logic                             valid;
  logic                             ready;
  logic [qph_pkg::OUTCOME_W-1:0]    outcome;
  logic [qph_pkg::SLOT_W-1:0]       slot;
  logic [qph_pkg::COUNT_W-1:0]      probe_count;

  modport source (output valid, output outcome, output slot, output probe_count, input ready);
  modport sink   (input valid, input outcome, input slot, input probe_count, output ready);
endinterface

@@ rtl/qph_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module qph_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/qph_ctrl.sv @@
// Sequencer: clearing pass, key reduction, probe read/check loop, result handoff.
// Depends on qph_pkg.
`timescale 1ns / 1ps

module qph_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  qph_pkg::sts_t sts,
  output qph_pkg::cmd_t cmd
);

  qph_pkg::state_t state_r, state_nxt;
  logic            stop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qph_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign stop = sts.slot_empty || (sts.is_lookup && sts.key_match) || sts.last_probe;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      qph_pkg::ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) begin
          state_nxt = qph_pkg::ST_IDLE;
        end
      end
      qph_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = qph_pkg::ST_DIV;
        end
      end
      qph_pkg::ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = qph_pkg::ST_INIT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      qph_pkg::ST_INIT: begin
        cmd.probe_init = 1'b1;
        state_nxt      = qph_pkg::ST_READ;
      end
      qph_pkg::ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = qph_pkg::ST_CHECK;
      end
      qph_pkg::ST_CHECK: begin
        if (stop) begin
          // hold here until the output register can take the result
          if (!sts.out_busy) begin
            cmd.out_load = 1'b1;
            cmd.wr       = !sts.is_lookup && sts.slot_empty;
            state_nxt    = qph_pkg::ST_IDLE;
          end
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = qph_pkg::ST_READ;
        end
      end
      default: begin
        state_nxt = qph_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

@@ rtl/qph_dp.sv @@
// Datapath: size register, bit-serial key mod size, incremental probe position,
// slot store and result register. Depends on qph_pkg and qph_ram.
`timescale 1ns / 1ps

module qph_dp #(
  parameter int TABLE_DEPTH = 16384,
  parameter int KEY_WIDTH   = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [qph_pkg::SIZE_W-1:0]         cfg_wdata,
  input  logic                               in_opcode,
  input  logic [KEY_WIDTH-1:0]               in_key,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [qph_pkg::OUTCOME_W-1:0]      out_outcome,
  output logic [qph_pkg::SLOT_W-1:0]         out_slot,
  output logic [qph_pkg::COUNT_W-1:0]        out_probe_count,
  input  qph_pkg::cmd_t                      cmd,
  output qph_pkg::sts_t                      sts
);

  localparam int SW    = qph_pkg::SIZE_W;
  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW    = $clog2(KEY_WIDTH + 1);
  localparam int CAP_I = (TABLE_DEPTH > (2 ** SW) - 1) ? (2 ** SW) - 1 : TABLE_DEPTH;
  localparam logic [SW-1:0] DEPTH_CAP = SW'(CAP_I);
  localparam logic [AW-1:0] CLR_LAST  = AW'(TABLE_DEPTH - 1);

  logic [SW-1:0]        table_size_r;
  logic [SW-1:0]        n;
  logic [KEY_WIDTH-1:0] key_r;
  logic [KEY_WIDTH-1:0] sh_r;
  logic                 op_r;
  logic [CW-1:0]        cnt_r;
  logic [SW-1:0]        rem_r;
  logic [SW-1:0]        pos_r;
  logic [SW-1:0]        d_r;
  logic [SW-1:0]        j_r;
  logic [AW-1:0]        clr_cnt_r;
  logic                 out_valid_r;
  logic [qph_pkg::OUTCOME_W-1:0] outcome_r;
  logic [qph_pkg::SLOT_W-1:0]    slot_r;
  logic [qph_pkg::COUNT_W-1:0]   count_r;

  logic [SW:0]          div_t;
  logic [SW:0]          pos_sum;
  logic [SW-1:0]        pos_nxt;
  logic [SW:0]          d_s1;
  logic [SW:0]          d_s2;
  logic [SW-1:0]        d_nxt;
  logic [SW-1:0]        rem_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [KEY_WIDTH:0]   ram_wdata;
  logic [KEY_WIDTH:0]   ram_rdata;
  logic                 slot_empty;
  logic                 key_match;

  // effective size: zero acts as one, capped at the store depth
  always_comb begin
    if (table_size_r == '0) begin
      n = SW'(1);
    end else if (table_size_r > DEPTH_CAP) begin
      n = DEPTH_CAP;
    end else begin
      n = table_size_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= qph_pkg::TABLE_SIZE_RST;
    end else if (cfg_we) begin
      table_size_r <= cfg_wdata;
    end
  end

  // restoring remainder, one key bit per cycle, MSB first
  assign div_t   = {rem_r, sh_r[KEY_WIDTH-1]};
  assign rem_nxt = (div_t >= {1'b0, n}) ? SW'(div_t - {1'b0, n}) : div_t[SW-1:0];

  // pos += (2j+1) mod n ; d += 2 mod n (two subtracts cover n == 1)
  assign pos_sum = {1'b0, pos_r} + {1'b0, d_r};
  assign pos_nxt = (pos_sum >= {1'b0, n}) ? SW'(pos_sum - {1'b0, n}) : pos_sum[SW-1:0];
  assign d_s1    = {1'b0, d_r} + (SW+1)'(2);
  assign d_s2    = (d_s1 >= {1'b0, n}) ? d_s1 - {1'b0, n} : d_s1;
  assign d_nxt   = (d_s2 >= {1'b0, n}) ? SW'(d_s2 - {1'b0, n}) : d_s2[SW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.start) begin
      cnt_r <= CW'(KEY_WIDTH);
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r <= in_key;
      sh_r  <= in_key;
      op_r  <= in_opcode;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      sh_r  <= {sh_r[KEY_WIDTH-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
    if (cmd.probe_init) begin
      pos_r <= rem_r;
      d_r   <= (n == SW'(1)) ? '0 : SW'(1);
      j_r   <= '0;
    end else if (cmd.advance) begin
      pos_r <= pos_nxt;
      d_r   <= d_nxt;
      j_r   <= j_r + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  assign ram_we    = cmd.clr || cmd.wr;
  assign ram_waddr = cmd.clr ? clr_cnt_r : AW'(pos_r);
  assign ram_wdata = cmd.clr ? '0 : {1'b1, key_r};

  // each entry: {valid, key}
  qph_ram #(
    .WIDTH (KEY_WIDTH + 1),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (AW'(pos_r)),
    .rdata (ram_rdata)
  );

  assign slot_empty = !ram_rdata[KEY_WIDTH];
  assign key_match  = (ram_rdata[KEY_WIDTH-1:0] == key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (slot_empty) begin
        outcome_r <= (op_r == qph_pkg::OP_LOOKUP) ? qph_pkg::OUT_EMPTY : qph_pkg::OUT_INSERTED;
        slot_r    <= qph_pkg::SLOT_W'(pos_r);
        count_r   <= qph_pkg::COUNT_W'(j_r + SW'(1));
      end else if (op_r == qph_pkg::OP_LOOKUP && key_match) begin
        outcome_r <= qph_pkg::OUT_FOUND;
        slot_r    <= qph_pkg::SLOT_W'(pos_r);
        count_r   <= qph_pkg::COUNT_W'(j_r + SW'(1));
      end else if (op_r == qph_pkg::OP_LOOKUP) begin
        outcome_r <= qph_pkg::OUT_EXHAUSTED;
        slot_r    <= '0;
        count_r   <= qph_pkg::COUNT_W'(n + SW'(1));
      end else begin
        outcome_r <= qph_pkg::OUT_INSERT_FAILED;
        slot_r    <= '0;
        count_r   <= qph_pkg::COUNT_W'(n);
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_outcome     = outcome_r;
  assign out_slot        = slot_r;
  assign out_probe_count = count_r;

  assign sts.clr_done   = (clr_cnt_r == CLR_LAST);
  assign sts.div_done   = (cnt_r == '0);
  assign sts.slot_empty = slot_empty;
  assign sts.key_match  = key_match;
  assign sts.last_probe = (j_r == n - SW'(1));
  assign sts.is_lookup  = (op_r == qph_pkg::OP_LOOKUP);
  assign sts.out_busy   = out_valid_r && !out_ready;

endmodule

@@ rtl/quadratic_probe_hash_table.sv @@
// From accept to result valid: key mod size, one key bit per cycle, then probe setup,
// then each probe as a RAM read followed by a check.
// Items are taken one at a time: the next is accepted only once the last is done, but the
// result register lets the next item start while a result waits. Reset: synchronous,
// active low; then a clearing pass empties every slot before the first accept.
// Depends on qph_pkg, qph_if, qph_ctrl, qph_dp, qph_ram.
`timescale 1ns / 1ps

module quadratic_probe_hash_table #(
  parameter int TABLE_DEPTH = 16384,
  parameter int KEY_WIDTH   = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [qph_pkg::SIZE_W-1:0] cfg_wdata,
  qph_in_if.sink                     in_ch,
  qph_out_if.source                  out_ch
);

  qph_pkg::cmd_t cmd;
  qph_pkg::sts_t sts;
  logic          in_ready;

  assign in_ch.ready = in_ready;

  qph_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  qph_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_opcode       (in_ch.opcode),
    .in_key          (in_ch.key),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_outcome     (out_ch.outcome),
    .out_slot        (out_ch.slot),
    .out_probe_count (out_ch.probe_count),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

@@ rtl/qph_chk.sv @@
// Port-level assertions for the hash table, bound to the top level.
// Depends on qph_pkg and quadratic_probe_hash_table.
`timescale 1ns / 1ps

module qph_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [qph_pkg::OUTCOME_W-1:0] outcome,
  input logic [qph_pkg::SLOT_W-1:0]    slot,
  input logic [qph_pkg::COUNT_W-1:0]   probe_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted while busy");

  a_no_slot_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (outcome == qph_pkg::OUT_INSERT_FAILED || outcome == qph_pkg::OUT_EXHAUSTED)
    |-> slot == '0)
    else $error("nonzero slot on failed insert or exhausted lookup");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> probe_count != '0)
    else $error("zero probe count");

endmodule

bind quadratic_probe_hash_table qph_chk u_qph_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .outcome     (out_ch.outcome),
  .slot        (out_ch.slot),
  .probe_count (out_ch.probe_count)
);

@@ bench/qph_checker.sv @@
// Checker for the quadratic-probe hash table: mirrors the key store, predicts each result.
// Watches the config port and both channels. Depends on qph_pkg and qph_if.
`timescale 1ns / 1ps

module qph_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [qph_pkg::SIZE_W-1:0] cfg_wdata,
  qph_in_if                          in_ch,
  qph_out_if                         out_ch,
  output int unsigned                fail_count,
  output int unsigned                pending
);
  import qph_pkg::*;

  localparam int unsigned DEPTH = 16384;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic [SLOT_W-1:0]    slot;
    logic [COUNT_W-1:0]   probe_count;
  } probe_result_t;

  logic [SIZE_W-1:0] table_size;
  logic [31:0]       slot_keys [DEPTH];
  bit                slot_used [DEPTH];
  probe_result_t     probe_results_q [$];
  int unsigned       fails;

  // size 0 acts as 1, anything past the store depth is clamped
  function automatic int unsigned live_size();
    if (table_size == '0) return 1;
    if (table_size > DEPTH) return DEPTH;
    return table_size;
  endfunction

  // Walks the probe sequence, updating the mirrored store on a successful insert.
  function automatic probe_result_t run_probe(input logic op, input logic [31:0] key);
    probe_result_t res;
    int unsigned   n;
    int unsigned   base;
    int unsigned   pos;
    n    = live_size();
    base = key % n;
    for (int unsigned j = 0; j < n; j++) begin
      pos = (base + (j * j) % n) % n;
      res.slot        = pos[SLOT_W-1:0];
      res.probe_count = COUNT_W'(j + 1);
      if (!slot_used[pos]) begin
        if (op == OP_INSERT) begin
          slot_keys[pos] = key;
          slot_used[pos] = 1'b1;
          res.outcome    = OUT_INSERTED;
        end else begin
          res.outcome = OUT_EMPTY;
        end
        return res;
      end
      if (op == OP_LOOKUP && slot_keys[pos] == key) begin
        res.outcome = OUT_FOUND;
        return res;
      end
    end
    res.slot = '0;
    if (op == OP_INSERT) begin
      res.outcome     = OUT_INSERT_FAILED;
      res.probe_count = COUNT_W'(n);
    end else begin
      res.outcome     = OUT_EXHAUSTED;
      res.probe_count = COUNT_W'(n + 1);
    end
    return res;
  endfunction

  function automatic void compare_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    probe_result_t want;
    if (!rst_n) begin
      table_size = TABLE_SIZE_RST;
      for (int unsigned i = 0; i < DEPTH; i++) slot_used[i] = 1'b0;
      probe_results_q.delete();
      fails = 0;
    end else begin
      if (cfg_we) table_size = cfg_wdata;
      // retire results before queuing new ones: latency rules out same-cycle turnaround
      if (out_ch.valid && out_ch.ready) begin
        if (probe_results_q.size() == 0) begin
          $display("%0t: unexpected transaction: expected none, got outcome %0d slot %0d count %0d",
                   $time, out_ch.outcome, out_ch.slot, out_ch.probe_count);
          fails++;
        end else begin
          want = probe_results_q.pop_front();
          compare_field("outcome", 32'(want.outcome), 32'(out_ch.outcome));
          compare_field("slot", 32'(want.slot), 32'(out_ch.slot));
          compare_field("probe_count", 32'(want.probe_count), 32'(out_ch.probe_count));
        end
      end
      if (in_ch.valid && in_ch.ready)
        probe_results_q.push_back(run_probe(in_ch.opcode, in_ch.key));
    end
    fail_count <= fails;
    pending    <= probe_results_q.size();
  end

endmodule

@@ bench/testbench.sv @@
// Top of the hash table bench: clock, reset, table size writes, request and stall traffic.
// Depends on qph_pkg, qph_if, qph_checker and quadratic_probe_hash_table.
`timescale 1ns / 1ps

module testbench;
  import qph_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 200000;
  localparam int unsigned TAIL_CYCLES    = 300;
  localparam int unsigned PHASES         = 16;
  localparam int unsigned PHASE_ITEMS    = 112;
  localparam int unsigned POOL_MAX       = 256;
  localparam int unsigned SMALL_PRIMES [8] = '{2, 3, 5, 7, 11, 13, 17, 31};
  localparam int unsigned MID_PRIMES   [6] = '{97, 251, 509, 1021, 2039, 4093};

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;
  int unsigned       fail_count;
  int unsigned       pending;
  int unsigned       quiet_cycles = 0;
  int unsigned       burst_left = 0;
  bit                steady_sender = 1'b0;
  logic [31:0]       key_pool [$];

  qph_in_if #(.KEY_WIDTH(32)) in_ch ();
  qph_out_if                  out_ch ();

  quadratic_probe_hash_table u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  qph_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sender runs in bursts; a gap lowers valid only when it is nonzero.
  task automatic send_item(input logic op, input logic [31:0] key);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = steady_sender ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.key    <= key;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_table_size(input logic [SIZE_W-1:0] size);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Receiver stall pattern: free-running, switching between randomly chosen modes.
  initial begin
    int unsigned mode;
    int unsigned left;
    int unsigned tick;
    out_ch.ready <= 1'b0;
    mode = 0;
    left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 150);
      end
      left--;
      tick++;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 1) == 1);
        2: out_ch.ready <= (tick % 4 == 0);
        default: out_ch.ready <= (tick % 32 >= 24);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [SIZE_W-1:0] size;
    int unsigned       stride;
    int unsigned       pick;
    logic [31:0]       key;
    in_ch.valid  <= 1'b0;
    in_ch.opcode <= OP_INSERT;
    in_ch.key    <= '0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    rst_n        <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // default size: key extremes, duplicate insert, colliding miss
    send_item(OP_INSERT, 32'h0000_0000);
    send_item(OP_INSERT, 32'hFFFF_FFFF);
    send_item(OP_LOOKUP, 32'h0000_0000);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'h0000_0000);
    send_item(OP_LOOKUP, 32'd16381);
    send_item(OP_LOOKUP, 32'h1234_5678);
    // size 0 behaves as a single slot
    set_table_size('0);
    send_item(OP_INSERT, 32'd5);
    send_item(OP_LOOKUP, 32'd0);
    send_item(OP_LOOKUP, 32'd7);
    // oversize clamps to the store depth
    set_table_size('1);
    send_item(OP_INSERT, 32'hFFFF_FFFF);
    send_item(OP_LOOKUP, 32'hFFFF_FFFF);
    send_item(OP_LOOKUP, 32'h7FFF_FFFF);
    send_item(OP_INSERT, 32'h8000_0000);
    // smallest size above one, slots already taken from earlier phases
    set_table_size(SIZE_W'(2));
    send_item(OP_INSERT, 32'd1);
    send_item(OP_LOOKUP, 32'd2);
    send_item(OP_LOOKUP, 32'd0);
    send_item(OP_INSERT, 32'd3);
    set_table_size(SIZE_W'(16384));
    send_item(OP_INSERT, 32'd16383);
    send_item(OP_LOOKUP, 32'd16383);

    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: size = SIZE_W'(SMALL_PRIMES[$urandom_range(0, 7)]);
        3, 4:    size = SIZE_W'(MID_PRIMES[$urandom_range(0, 5)]);
        5:       size = SIZE_W'($urandom_range(0, 40));
        6:       size = SIZE_W'($urandom_range(16370, 16384));
        7:       size = SIZE_W'($urandom_range(16385, 32767));
        default: size = SIZE_W'($urandom_range(41, 4096));
      endcase
      set_table_size(size);
      stride = (size == '0) ? 1 : ((size > 16384) ? 16384 : size);
      steady_sender = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 35 || key_pool.size() == 0) begin
          key = $urandom;
          send_item(OP_INSERT, key);
          key_pool.push_back(key);
        end else if (pick < 70) begin
          send_item(OP_LOOKUP, key_pool[$urandom_range(0, key_pool.size() - 1)]);
        end else if (pick < 80) begin
          // same home slot as a stored key, forces probing
          key = key_pool[$urandom_range(0, key_pool.size() - 1)] +
                32'(stride * $urandom_range(1, 4000));
          send_item(OP_INSERT, key);
          key_pool.push_back(key);
        end else if (pick < 88) begin
          key = key_pool[$urandom_range(0, key_pool.size() - 1)] +
                32'(stride * $urandom_range(1, 4000));
          send_item(OP_LOOKUP, key);
        end else if (pick < 94) begin
          send_item(OP_LOOKUP, $urandom);
        end else begin
          send_item(OP_INSERT, key_pool[$urandom_range(0, key_pool.size() - 1)]);
        end
        if (key_pool.size() > POOL_MAX) void'(key_pool.pop_front());
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
